// File: hw/rtl/ctcgd_pkg.sv
// Shared types and constants for the CTC greedy decoder.
package ctcgd_pkg;

    localparam int SCORE_W    = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int NCLS_W     = 11;
    localparam int CLASS_W    = 10;
    localparam int LEN_W      = 13;
    localparam int OUT_DATA_W = CLASS_W + LEN_W + 1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_NUM_CLASSES    = 2'd0,
        REG_BLANK_INDEX    = 2'd1,
        REG_MERGE_REPEATED = 2'd2,
        REG_MAX_STEPS      = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        CMD_SCORE = 1'b0,
        CMD_END   = 1'b1
    } cmd_t;

    typedef enum logic {
        KIND_SYMBOL  = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    localparam logic [NCLS_W-1:0]  RST_NUM_CLASSES    = 11'd1024;
    localparam logic [CLASS_W-1:0] RST_BLANK_INDEX    = 10'd1023;
    localparam logic               RST_MERGE_REPEATED = 1'b1;
    localparam logic [LEN_W-1:0]   RST_MAX_STEPS      = 13'd4096;

endpackage

// File: hw/rtl/ctc_greedy_decoder.sv
// CTC greedy decoder: streaming argmax per time step with blank and repeat removal.
// Takes one transfer per cycle: a class score or an end-of-sequence command. Each item
// passes from an input register through one compare-and-update of the running argmax
// to a result register, so one item is accepted in every cycle while the result side
// is not stalled; a stalled result holds both stages. The last score of a step
// produces a class symbol unless the step's argmax is the blank or a merged repeat; an
// end command produces a summary with the decoded length and a too-long flag, then
// clears all sequence state. A partial step at the end command is discarded, steps past
// max_steps are dropped and flagged. Configuration writes take effect at the next edge
// and must be made while no item is in flight.
module ctc_greedy_decoder #(
    parameter int MAX_CLASSES    = 1024,
    parameter int MAX_TIME_STEPS = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [ctcgd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ctcgd_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ctcgd_pkg::SCORE_W-1:0]       s_tdata,   // [31:0] score
    input  logic                                s_tuser,   // [0] cmd
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ctcgd_pkg::OUT_DATA_W-1:0]    m_tdata,   // [9:0] class_index,
                                                           // [22:10] decoded_length,
                                                           // [23] too_long
    output logic                                m_tuser    // [0] result_kind
);

    localparam int CNT_W = $clog2(MAX_CLASSES + 1);
    localparam int IDX_W = $clog2(MAX_CLASSES);
    localparam int STP_W = $clog2(MAX_TIME_STEPS + 1);
    localparam int NCW   = (CNT_W > ctcgd_pkg::NCLS_W) ? CNT_W : ctcgd_pkg::NCLS_W;
    localparam int MSW   = (STP_W > ctcgd_pkg::LEN_W) ? STP_W : ctcgd_pkg::LEN_W;
    localparam int BCW   = (IDX_W > ctcgd_pkg::CLASS_W) ? IDX_W : ctcgd_pkg::CLASS_W;

    // configuration registers
    logic [ctcgd_pkg::NCLS_W-1:0]  num_classes_reg;
    logic [ctcgd_pkg::CLASS_W-1:0] blank_index_reg;
    logic                          merge_repeated_reg;
    logic [ctcgd_pkg::LEN_W-1:0]   max_steps_reg;

    // input stage
    logic                          in_valid_reg;
    ctcgd_pkg::cmd_t               in_cmd_reg;
    logic signed [ctcgd_pkg::SCORE_W-1:0] in_score_reg;

    // sequence state
    logic signed [ctcgd_pkg::SCORE_W-1:0] best_score_reg, best_score_next;
    logic [IDX_W-1:0]              best_class_reg, best_class_next;
    logic [CNT_W-1:0]              class_cnt_reg, class_cnt_next;
    logic [IDX_W-1:0]              prev_class_reg, prev_class_next;
    logic                          prev_valid_reg, prev_valid_next;
    logic [STP_W-1:0]              step_cnt_reg, step_cnt_next;
    logic [STP_W-1:0]              emitted_reg, emitted_next;
    logic                          overflow_reg, overflow_next;

    // result stage
    logic                          out_valid_reg, out_valid_next;
    ctcgd_pkg::kind_t              out_kind_reg, out_kind_next;
    logic [ctcgd_pkg::CLASS_W-1:0] out_class_reg, out_class_next;
    logic [ctcgd_pkg::LEN_W-1:0]   out_len_reg, out_len_next;
    logic                          out_long_reg, out_long_next;

    logic                          out_free;
    logic                          proc;
    logic                          take;
    logic [CNT_W-1:0]              cnt_inc;
    logic [NCW-1:0]                nc_ext;
    logic [NCW-1:0]                eff_c;
    logic [MSW-1:0]                ms_ext;
    logic [MSW-1:0]                eff_max;
    logic                          step_done;
    logic [IDX_W-1:0]              step_class;
    logic                          emit;

    assign out_free = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // effective class count and step limit
    always_comb
    begin
        nc_ext = NCW'(num_classes_reg);
        eff_c  = (nc_ext > NCW'(MAX_CLASSES)) ? NCW'(MAX_CLASSES) : nc_ext;
        if (eff_c == '0)
        begin
            eff_c = NCW'(1);
        end
        ms_ext  = MSW'(max_steps_reg);
        eff_max = (ms_ext > MSW'(MAX_TIME_STEPS)) ? MSW'(MAX_TIME_STEPS) : ms_ext;
    end

    always_comb
    begin
        take       = (class_cnt_reg == '0) || (in_score_reg > best_score_reg);
        cnt_inc    = class_cnt_reg + CNT_W'(1);
        step_done  = NCW'(cnt_inc) >= eff_c;
        step_class = take ? IDX_W'(class_cnt_reg) : best_class_reg;
        emit       = (BCW'(step_class) != BCW'(blank_index_reg)) &&
                     !(merge_repeated_reg && prev_valid_reg && (step_class == prev_class_reg));

        best_score_next = best_score_reg;
        best_class_next = best_class_reg;
        class_cnt_next  = class_cnt_reg;
        prev_class_next = prev_class_reg;
        prev_valid_next = prev_valid_reg;
        step_cnt_next   = step_cnt_reg;
        emitted_next    = emitted_reg;
        overflow_next   = overflow_reg;

        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_class_next  = out_class_reg;
        out_len_next    = out_len_reg;
        out_long_next   = out_long_reg;

        if (proc)
        begin
            if (in_cmd_reg == ctcgd_pkg::CMD_END)
            begin
                out_valid_next  = 1'b1;
                out_kind_next   = ctcgd_pkg::KIND_SUMMARY;
                out_class_next  = '0;
                out_len_next    = ctcgd_pkg::LEN_W'(emitted_reg);
                out_long_next   = overflow_reg;
                best_score_next = '0;
                best_class_next = '0;
                class_cnt_next  = '0;
                prev_class_next = '0;
                prev_valid_next = 1'b0;
                step_cnt_next   = '0;
                emitted_next    = '0;
                overflow_next   = 1'b0;
            end
            else if (!step_done)
            begin
                // accumulate the running maximum of this step
                best_score_next = take ? in_score_reg : best_score_reg;
                best_class_next = step_class;
                class_cnt_next  = cnt_inc;
            end
            else
            begin
                best_score_next = '0;
                best_class_next = '0;
                class_cnt_next  = '0;
                if (MSW'(step_cnt_reg) >= eff_max)
                begin
                    // drop the step, flag the overrun
                    overflow_next = 1'b1;
                end
                else
                begin
                    step_cnt_next   = step_cnt_reg + STP_W'(1);
                    prev_class_next = step_class;
                    prev_valid_next = 1'b1;
                    if (emit)
                    begin
                        emitted_next   = emitted_reg + STP_W'(1);
                        out_valid_next = 1'b1;
                        out_kind_next  = ctcgd_pkg::KIND_SYMBOL;
                        out_class_next = ctcgd_pkg::CLASS_W'(step_class);
                        out_len_next   = '0;
                        out_long_next  = 1'b0;
                    end
                end
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_classes_reg    <= ctcgd_pkg::RST_NUM_CLASSES;
            blank_index_reg    <= ctcgd_pkg::RST_BLANK_INDEX;
            merge_repeated_reg <= ctcgd_pkg::RST_MERGE_REPEATED;
            max_steps_reg      <= ctcgd_pkg::RST_MAX_STEPS;
        end
        else if (cfg_we)
        begin
            case (ctcgd_pkg::cfg_reg_t'(cfg_addr))
                ctcgd_pkg::REG_NUM_CLASSES:
                    num_classes_reg <= cfg_data[ctcgd_pkg::NCLS_W-1:0];
                ctcgd_pkg::REG_BLANK_INDEX:
                    blank_index_reg <= cfg_data[ctcgd_pkg::CLASS_W-1:0];
                ctcgd_pkg::REG_MERGE_REPEATED:
                    merge_repeated_reg <= cfg_data[0];
                ctcgd_pkg::REG_MAX_STEPS:
                    max_steps_reg <= cfg_data[ctcgd_pkg::LEN_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg   <= ctcgd_pkg::cmd_t'(s_tuser);
            in_score_reg <= s_tdata;
        end
    end

    // sequence state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_score_reg <= '0;
            best_class_reg <= '0;
            class_cnt_reg  <= '0;
            prev_class_reg <= '0;
            prev_valid_reg <= 1'b0;
            step_cnt_reg   <= '0;
            emitted_reg    <= '0;
            overflow_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            best_score_reg <= best_score_next;
            best_class_reg <= best_class_next;
            class_cnt_reg  <= class_cnt_next;
            prev_class_reg <= prev_class_next;
            prev_valid_reg <= prev_valid_next;
            step_cnt_reg   <= step_cnt_next;
            emitted_reg    <= emitted_next;
            overflow_reg   <= overflow_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg  <= out_kind_next;
        out_class_reg <= out_class_next;
        out_len_reg   <= out_len_next;
        out_long_reg  <= out_long_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_long_reg, out_len_reg, out_class_reg};

    a_emitted_le_steps: assert property (@(posedge clk) disable iff (!rst_n)
        emitted_reg <= step_cnt_reg)
        else $error("more symbols emitted than steps decoded");

    a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        class_cnt_reg < CNT_W'(MAX_CLASSES))
        else $error("class counter out of range");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled with a free stage");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_cmd_reg == ctcgd_pkg::CMD_END |=>
            emitted_reg == '0 && step_cnt_reg == '0 && !overflow_reg && !prev_valid_reg
            && m_tvalid && m_tuser == ctcgd_pkg::KIND_SUMMARY)
        else $error("end command did not report and clear the sequence");

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the CTC greedy decoder: driver, monitor, argmax predictor.
module tb_top;

    localparam int TB_MAX_CLASSES = 1024;
    localparam int TB_MAX_STEPS   = 4096;
    localparam int RANDOM_ITEMS   = 40;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        ctcgd_pkg::cmd_t                cmd;
        logic [ctcgd_pkg::SCORE_W-1:0]  score;
    } score_item_t;

    typedef struct packed {
        ctcgd_pkg::kind_t               kind;
        logic [ctcgd_pkg::CLASS_W-1:0]  cls;
        logic [ctcgd_pkg::LEN_W-1:0]    len;
        logic                           too_long;
    } dec_result_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_we;
    logic [ctcgd_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [ctcgd_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [ctcgd_pkg::SCORE_W-1:0]    s_tdata;
    logic                             s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [ctcgd_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                             m_tuser;

    score_item_t pending_items[$];
    dec_result_t expected_results[$];
    int          queued_items = 0;
    int          mismatches   = 0;
    int          cycle_cnt    = 0;
    bit          s_acc        = 1'b0;

    // decoder settings as the predictor sees them
    int mdl_num_classes;
    int mdl_blank;
    int mdl_merge;
    int mdl_max_steps;

    // per-sequence decode state
    logic signed [ctcgd_pkg::SCORE_W-1:0] run_best_score;
    int run_best_class;
    int run_class_cnt;
    int prev_cls;
    bit prev_ok;
    int step_cnt;
    int emit_cnt;
    bit overflow_seen;

    ctc_greedy_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    task automatic clear_decode_state();
        run_best_score = '0;
        run_best_class = 0;
        run_class_cnt  = 0;
        prev_cls       = 0;
        prev_ok        = 1'b0;
        step_cnt       = 0;
        emit_cnt       = 0;
        overflow_seen  = 1'b0;
    endtask

    // Work out the result, if any, of one accepted transfer.
    task automatic decode_item(input ctcgd_pkg::cmd_t cmd,
                               input logic signed [ctcgd_pkg::SCORE_W-1:0] score);
        dec_result_t res;
        int          eff_c;
        int          eff_max;
        int          cls;
        bit          emit;
        if (cmd == ctcgd_pkg::CMD_END)
        begin
            res.kind     = ctcgd_pkg::KIND_SUMMARY;
            res.cls      = '0;
            res.len      = ctcgd_pkg::LEN_W'(emit_cnt);
            res.too_long = overflow_seen;
            expected_results.push_back(res);
            clear_decode_state();
        end
        else
        begin
            if (run_class_cnt == 0 || score > run_best_score)
            begin
                run_best_score = score;
                run_best_class = run_class_cnt;
            end
            run_class_cnt++;
            eff_c = mdl_num_classes;
            if (eff_c < 1)
                eff_c = 1;
            if (eff_c > TB_MAX_CLASSES)
                eff_c = TB_MAX_CLASSES;
            if (run_class_cnt >= eff_c)
            begin
                cls            = run_best_class;
                run_class_cnt  = 0;
                run_best_score = '0;
                run_best_class = 0;
                eff_max = (mdl_max_steps > TB_MAX_STEPS) ? TB_MAX_STEPS : mdl_max_steps;
                // drop the step past the limit, leaving the previous class alone
                if (step_cnt >= eff_max)
                    overflow_seen = 1'b1;
                else
                begin
                    step_cnt++;
                    emit = (cls != mdl_blank) &&
                           !(mdl_merge != 0 && prev_ok && cls == prev_cls);
                    prev_cls = cls;
                    prev_ok  = 1'b1;
                    if (emit)
                    begin
                        emit_cnt++;
                        res.kind     = ctcgd_pkg::KIND_SYMBOL;
                        res.cls      = ctcgd_pkg::CLASS_W'(cls);
                        res.len      = '0;
                        res.too_long = 1'b0;
                        expected_results.push_back(res);
                    end
                end
            end
        end
    endtask

    task automatic push_item(input ctcgd_pkg::cmd_t cmd,
                             input logic [ctcgd_pkg::SCORE_W-1:0] score);
        score_item_t it;
        it.cmd   = cmd;
        it.score = score;
        pending_items.push_back(it);
        queued_items++;
    endtask

    // Queue one whole time step; the winner is forced, or repeats, hits the blank or is random.
    task automatic push_step(input int n_scores, input int blank_cls, input int forced_win,
                             inout int last_win);
        int                            win;
        int                            mode;
        int                            pick;
        int                            k;
        logic [ctcgd_pkg::SCORE_W-1:0] top;
        logic [ctcgd_pkg::SCORE_W-1:0] v;
        if (forced_win >= 0)
            win = forced_win;
        else
        begin
            pick = $urandom_range(99, 0);
            if (pick < 40)
                win = last_win;
            else if (pick < 65)
                win = blank_cls;
            else
                win = $urandom_range(n_scores - 1, 0);
        end
        if (win < 0 || win >= n_scores)
            win = $urandom_range(n_scores - 1, 0);
        mode = (forced_win >= 0) ? 99 : $urandom_range(99, 0);
        top  = ($urandom_range(3, 0) == 0) ? 32'h7FFF_FFFF
                                            : ($urandom | 32'h4000_0000) & 32'h7FFF_FFFF;
        for (k = 0; k < n_scores; k++)
        begin
            if (mode < 15)
                v = $urandom;
            else if (mode < 30)
                v = ctcgd_pkg::SCORE_W'($urandom_range(2, 0)) - 1;
            else if (mode < 40)
            begin
                case ($urandom_range(3, 0))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            else if (k == win || (k > win && $urandom_range(7, 0) == 0))
                v = top;
            else
                v = $urandom & 32'hBFFF_FFFF;
            push_item(ctcgd_pkg::CMD_SCORE, v);
        end
        last_win = win;
    endtask

    // Hold until every transfer has gone and every result has come, then let the pipe empty.
    task automatic wait_idle();
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input ctcgd_pkg::cfg_reg_t idx, input int val);
        logic [ctcgd_pkg::CFG_DATA_W-1:0] data;
        // fill the unused upper bits with noise
        data = ctcgd_pkg::CFG_DATA_W'($urandom);
        case (idx)
            ctcgd_pkg::REG_NUM_CLASSES:
            begin
                data[ctcgd_pkg::NCLS_W-1:0] = ctcgd_pkg::NCLS_W'(val);
                mdl_num_classes = int'(data[ctcgd_pkg::NCLS_W-1:0]);
            end
            ctcgd_pkg::REG_BLANK_INDEX:
            begin
                data[ctcgd_pkg::CLASS_W-1:0] = ctcgd_pkg::CLASS_W'(val);
                mdl_blank = int'(data[ctcgd_pkg::CLASS_W-1:0]);
            end
            ctcgd_pkg::REG_MERGE_REPEATED:
            begin
                data[0]   = val[0];
                mdl_merge = int'(data[0]);
            end
            default:
            begin
                data          = ctcgd_pkg::LEN_W'(val);
                mdl_max_steps = int'(data);
            end
        endcase
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= data;
    endtask

    task automatic configure(input int nc, input int blank, input int merge, input int maxs);
        wait_idle();
        write_reg(ctcgd_pkg::REG_NUM_CLASSES, nc);
        write_reg(ctcgd_pkg::REG_BLANK_INDEX, blank);
        write_reg(ctcgd_pkg::REG_MERGE_REPEATED, merge);
        write_reg(ctcgd_pkg::REG_MAX_STEPS, maxs);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // input side: accept at the rising edge, drive at the falling edge
    always @(posedge clk)
    begin
        cycle_cnt++;
        s_acc = rst_n && s_tvalid && s_tready;
        if (s_acc)
        begin
            decode_item(ctcgd_pkg::cmd_t'(s_tuser), s_tdata);
            void'(pending_items.pop_front());
        end
    end

    always @(negedge clk)
    begin
        if (s_tvalid && !s_acc)
        begin
            // hold the offered transfer until it is taken
        end
        else if (pending_items.size() != 0 &&
                 ((cycle_cnt % 3000) >= 2200 || $urandom_range(99, 0) >= 13))
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= pending_items[0].score;
            s_tuser  <= pending_items[0].cmd;
        end
        else
            s_tvalid <= 1'b0;
    end

    // result side
    always @(negedge clk)
        m_tready <= ((cycle_cnt % 3000) >= 2200) || ($urandom_range(99, 0) >= 13);

    always @(posedge clk)
    begin : result_check
        dec_result_t got;
        dec_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind     = ctcgd_pkg::kind_t'(m_tuser);
            got.cls      = m_tdata[ctcgd_pkg::CLASS_W-1:0];
            got.len      = m_tdata[ctcgd_pkg::CLASS_W +: ctcgd_pkg::LEN_W];
            got.too_long = m_tdata[ctcgd_pkg::CLASS_W + ctcgd_pkg::LEN_W];
            if (expected_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: kind=%0d class=%0d len=%0d too_long=%0b",
                             got.kind, got.cls, got.len, got.too_long);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.kind !== want.kind || got.cls !== want.cls ||
                    got.len !== want.len || got.too_long !== want.too_long)
                begin
                    if (mismatches < 10)
                        $display("mismatch: expected kind=%0d class=%0d len=%0d too_long=%0b,",
                                 want.kind, want.cls, want.len, want.too_long,
                                 " got kind=%0d class=%0d len=%0d too_long=%0b",
                                 got.kind, got.cls, got.len, got.too_long);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int r;
        int nc;
        int gen_nc;
        int blank;
        int merge;
        int maxs;
        int phase_len;
        int phase_start;
        int rand_start;
        int nsteps;
        int last_win;
        int j;
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ctcgd_pkg::CMD_SCORE;
        m_tready = 1'b0;
        mdl_num_classes = int'(ctcgd_pkg::RST_NUM_CLASSES);
        mdl_blank       = int'(ctcgd_pkg::RST_BLANK_INDEX);
        mdl_merge       = int'(ctcgd_pkg::RST_MERGE_REPEATED);
        mdl_max_steps   = int'(ctcgd_pkg::RST_MAX_STEPS);
        clear_decode_state();
        last_win = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // two classes, blank at 0, limit of three steps
        configure(2, 0, 1, 3);
        push_item(ctcgd_pkg::CMD_END, 32'hFFFF_FFFF);          // empty sequence
        push_item(ctcgd_pkg::CMD_SCORE, 32'h7FFF_FFFF);        // blank step
        push_item(ctcgd_pkg::CMD_SCORE, 32'h8000_0000);
        push_item(ctcgd_pkg::CMD_SCORE, 32'h8000_0000);        // class 1 emitted
        push_item(ctcgd_pkg::CMD_SCORE, 32'h7FFF_FFFF);
        push_item(ctcgd_pkg::CMD_SCORE, 32'h0000_0007);        // tie, first index wins
        push_item(ctcgd_pkg::CMD_SCORE, 32'h0000_0007);
        push_item(ctcgd_pkg::CMD_SCORE, 32'hFFFF_FFFF);        // past the limit
        push_item(ctcgd_pkg::CMD_SCORE, 32'h0000_0000);
        push_item(ctcgd_pkg::CMD_SCORE, 32'h0000_0003);        // partial step, discarded
        push_item(ctcgd_pkg::CMD_END, 32'h0000_0000);

        // class count of zero, blank out of range, limit above the maximum, no merging
        configure(0, 1023, 0, 8191);
        push_item(ctcgd_pkg::CMD_SCORE, 32'hFFFF_FFFF);
        push_item(ctcgd_pkg::CMD_SCORE, 32'h0000_0000);
        push_item(ctcgd_pkg::CMD_SCORE, 32'h1234_5678);
        push_item(ctcgd_pkg::CMD_END, 32'h5555_AAAA);

        // zero step limit, then leave a partial step open
        configure(3, 1, 1, 0);
        push_item(ctcgd_pkg::CMD_SCORE, 32'h0000_0001);
        push_item(ctcgd_pkg::CMD_SCORE, 32'h0000_0002);
        push_item(ctcgd_pkg::CMD_SCORE, 32'h0000_0003);
        push_item(ctcgd_pkg::CMD_SCORE, 32'h0000_0005);
        push_item(ctcgd_pkg::CMD_SCORE, 32'h0000_0009);

        // lower the class count mid-step; then a merged repeat
        configure(2, 2, 1, 5);
        push_item(ctcgd_pkg::CMD_SCORE, 32'h0000_0001);
        push_item(ctcgd_pkg::CMD_SCORE, 32'h0000_0001);
        push_item(ctcgd_pkg::CMD_SCORE, 32'h0000_0009);
        push_item(ctcgd_pkg::CMD_END, 32'hAAAA_5555);

        rand_start = queued_items;
        while (queued_items - rand_start < RANDOM_ITEMS)
        begin
            r = $urandom_range(99, 0);
            if (r < 6)
                nc = 0;
            else if (r < 12)
                nc = 1;
            else if (r < 20)
                nc = $urandom_range(24, 6);
            else
                nc = $urandom_range(5, 2);
            gen_nc = (nc < 1) ? 1 : nc;
            r = $urandom_range(99, 0);
            if (r < 65)
                blank = $urandom_range(gen_nc - 1, 0);
            else if (r < 80)
                blank = 1023;
            else
                blank = $urandom_range(1023, 0);
            merge = $urandom_range(1, 0);
            r = $urandom_range(99, 0);
            if (r < 8)
                maxs = 0;
            else if (r < 30)
                maxs = $urandom_range(4, 1);
            else if (r < 40)
                maxs = $urandom_range(8191, 4097);
            else
                maxs = $urandom_range(4096, 5);
            configure(nc, blank, merge, maxs);

            phase_len   = $urandom_range(160, 30);
            phase_start = queued_items;
            while (queued_items - phase_start < phase_len)
            begin
                nsteps = $urandom_range(9, 0);
                for (j = 0; j < nsteps; j++)
                begin
                    // broken sequence: end arrives mid-step
                    if (gen_nc > 1 && $urandom_range(24, 0) == 0)
                    begin
                        repeat ($urandom_range(gen_nc - 1, 1))
                            push_item(ctcgd_pkg::CMD_SCORE, $urandom);
                        push_item(ctcgd_pkg::CMD_END, $urandom);
                    end
                    push_step(gen_nc, blank, -1, last_win);
                end
                if (gen_nc > 1 && $urandom_range(9, 0) == 0)
                    repeat ($urandom_range(gen_nc - 1, 1))
                        push_item(ctcgd_pkg::CMD_SCORE, $urandom);
                // now and then carry the sequence over into the next setting
                if ($urandom_range(9, 0) != 0)
                    push_item(ctcgd_pkg::CMD_END, $urandom);
            end
        end

        // full-width step: a class count above the maximum acts as the maximum,
        // and the top class index wins
        configure(2047, 0, 1, TB_MAX_STEPS);
        push_item(ctcgd_pkg::CMD_END, $urandom);
        push_step(TB_MAX_CLASSES, 0, 1023, last_win);
        repeat (10) push_item(ctcgd_pkg::CMD_SCORE, $urandom);
        push_item(ctcgd_pkg::CMD_END, $urandom);

        wait_idle();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/ctcgd_pkg.sv
hw/rtl/ctc_greedy_decoder.sv
dv/tb_top.sv
